// ----- hw/rtl/aslt_pkg.sv -----
// aslt_pkg: shared constants, codes and the queue entry type of the
// ambient sound level tracker. No dependencies.
package aslt_pkg;

  // coordinate width default, handed to the top level parameter
  localparam int COORD_WIDTH_DEF = 17;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MASK_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SKY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAVA  = 3'd4;

  localparam logic [MASK_W-1:0] SKY_MASK_RST   = 32'd4;
  localparam logic [MASK_W-1:0] SOLID_MASK_RST = 32'd1;
  localparam logic [MASK_W-1:0] WATER_MASK_RST = 32'd32;
  localparam logic [MASK_W-1:0] SLIME_MASK_RST = 32'd16;
  localparam logic [MASK_W-1:0] LAVA_MASK_RST  = 32'd8;

  // item function codes
  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_LEAF_LO = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LEAF_HI = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_VERTEX  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FINISH  = 2'd3;

  // sound classes
  localparam int CLASS_W = 2;
  localparam int NUM_CLASSES = 4;
  localparam logic [CLASS_W-1:0] CLASS_WATER = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SKY   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_SLIME = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_LAVA  = 2'd3;

  // distance and volume
  localparam int DIST_W  = 11;
  localparam int LEVEL_W = 8;
  localparam logic [DIST_W-1:0]  NEAR_LIMIT  = 11'd128;
  localparam logic [DIST_W-1:0]  FAR_LIMIT   = 11'd1024;
  localparam logic [LEVEL_W-1:0] FULL_VOLUME = 8'd255;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               fin;   // finish leaf, emit levels
    logic [CLASS_W-1:0] cls;   // class of a closed surface
    logic [DIST_W-1:0]  gap;   // saturated surface gap
  } aslt_op_t;

endpackage

// ----- hw/rtl/aslt_in_if.sv -----
// aslt_in_if: input item channel of the ambient sound level tracker.
// Depends on aslt_pkg.
interface aslt_in_if #(
  parameter int COORD_WIDTH = aslt_pkg::COORD_WIDTH_DEF
) ();
  import aslt_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [FUNC_W-1:0]             func;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;
  logic [MASK_W-1:0]             contents;
  logic                          last_vertex;

  modport source (
    output valid, func, x_coord, y_coord, z_coord, contents, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, func, x_coord, y_coord, z_coord, contents, last_vertex,
    output ready
  );

endinterface

// ----- hw/rtl/aslt_out_if.sv -----
// aslt_out_if: result item channel carrying the four sound levels.
// Depends on aslt_pkg.
interface aslt_out_if ();
  import aslt_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] water_level;
  logic [LEVEL_W-1:0] sky_level;
  logic [LEVEL_W-1:0] slime_level;
  logic [LEVEL_W-1:0] lava_level;

  modport source (
    output valid, water_level, sky_level, slime_level, lava_level,
    input  ready
  );

  modport sink (
    input  valid, water_level, sky_level, slime_level, lava_level,
    output ready
  );

endinterface

// ----- hw/rtl/aslt_queue.sv -----
// aslt_queue: short queue of classified operations between front and back.
// Depends on aslt_pkg.
module aslt_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  aslt_pkg::aslt_op_t        push_op,
  input  logic                      pop,
  output aslt_pkg::aslt_op_t        pop_op,
  output logic                      not_empty,
  output logic [aslt_pkg::QCNT_W-1:0] count
);
  import aslt_pkg::*;

  aslt_op_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_op;
  end

  assign pop_op    = entries[rd_ptr];
  assign not_empty = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QUEUE_DEPTH) || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue pop while empty");

endmodule

// ----- hw/rtl/aslt_front.sv -----
// aslt_front: accepts items, holds the leaf and surface boxes and the masks,
// classifies closed surfaces and measures their gap. Depends on aslt_pkg.
module aslt_front #(
  parameter int COORD_WIDTH = aslt_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [aslt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aslt_pkg::CFG_DATA_W-1:0] cfg_data,
  aslt_in_if.sink                       items,
  input  logic [aslt_pkg::QCNT_W-1:0]     q_count,
  output logic                          push,
  output aslt_pkg::aslt_op_t            push_op
);
  import aslt_pkg::*;

  localparam int GAP_W = COORD_WIDTH + 1;

  // configuration masks
  logic [MASK_W-1:0] sky_mask, solid_mask, water_mask, slime_mask, lava_mask;

  // leaf and surface boxes
  logic signed [COORD_WIDTH-1:0] leaf_lo [3];
  logic signed [COORD_WIDTH-1:0] leaf_hi [3];
  logic signed [COORD_WIDTH-1:0] surf_lo [3];
  logic signed [COORD_WIDTH-1:0] surf_hi [3];
  logic                          surf_open;

  // gap stage registers
  logic                          a_vld;
  logic                          a_fin;
  logic [CLASS_W-1:0]            a_cls;
  logic signed [COORD_WIDTH-1:0] a_surf_lo [3];
  logic signed [COORD_WIDTH-1:0] a_surf_hi [3];
  logic signed [COORD_WIDTH-1:0] a_leaf_lo [3];
  logic signed [COORD_WIDTH-1:0] a_leaf_hi [3];

  logic                          take;
  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [COORD_WIDTH-1:0] new_lo [3];
  logic signed [COORD_WIDTH-1:0] new_hi [3];
  logic                          cls_hit;
  logic [CLASS_W-1:0]            cls;
  logic [GAP_W-1:0]              gap_axis [3];
  logic [GAP_W-1:0]              gap_max;

  // room for one more item: queue plus the item in the gap stage
  assign items.ready = (q_count + QCNT_W'(a_vld)) < QCNT_W'(QUEUE_DEPTH);
  assign take        = items.valid && items.ready;

  assign pt[0] = items.x_coord;
  assign pt[1] = items.y_coord;
  assign pt[2] = items.z_coord;

  // grow the surface box, or start it on a first vertex
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!surf_open) begin
        new_lo[l] = pt[l];
        new_hi[l] = pt[l];
      end else begin
        new_lo[l] = (pt[l] < surf_lo[l]) ? pt[l] : surf_lo[l];
        new_hi[l] = (pt[l] > surf_hi[l]) ? pt[l] : surf_hi[l];
      end
    end
  end

  // classify content flags, sky first, solid surfaces dropped
  always_comb begin
    cls_hit = 1'b1;
    cls     = CLASS_SKY;
    if (|(items.contents & sky_mask)) begin
      cls = CLASS_SKY;
    end else if (|(items.contents & solid_mask)) begin
      cls_hit = 1'b0;
    end else if (|(items.contents & water_mask)) begin
      cls = CLASS_WATER;
    end else if (|(items.contents & slime_mask)) begin
      cls = CLASS_SLIME;
    end else if (|(items.contents & lava_mask)) begin
      cls = CLASS_LAVA;
    end else begin
      cls_hit = 1'b0;
    end
  end

  // control state and masks
  always_ff @(posedge clk) begin
    if (rst) begin
      sky_mask   <= SKY_MASK_RST;
      solid_mask <= SOLID_MASK_RST;
      water_mask <= WATER_MASK_RST;
      slime_mask <= SLIME_MASK_RST;
      lava_mask  <= LAVA_MASK_RST;
      for (int l = 0; l < 3; l++) begin
        leaf_lo[l] <= '0;
        leaf_hi[l] <= '0;
      end
      surf_open <= 1'b0;
      a_vld     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SKY:   sky_mask   <= cfg_data;
          CFG_SOLID: solid_mask <= cfg_data;
          CFG_WATER: water_mask <= cfg_data;
          CFG_SLIME: slime_mask <= cfg_data;
          CFG_LAVA:  lava_mask  <= cfg_data;
          default: ;
        endcase
      end
      a_vld <= 1'b0;
      if (take) begin
        case (items.func)
          FUNC_LEAF_LO: begin
            for (int l = 0; l < 3; l++) leaf_lo[l] <= pt[l];
          end
          FUNC_LEAF_HI: begin
            for (int l = 0; l < 3; l++) leaf_hi[l] <= pt[l];
          end
          FUNC_VERTEX: begin
            surf_open <= !items.last_vertex;
            a_vld     <= items.last_vertex && cls_hit;
          end
          FUNC_FINISH: begin
            surf_open <= 1'b0;
            a_vld     <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // surface box and gap stage payload
  always_ff @(posedge clk) begin
    if (take && items.func == FUNC_VERTEX) begin
      for (int l = 0; l < 3; l++) begin
        surf_lo[l] <= new_lo[l];
        surf_hi[l] <= new_hi[l];
      end
    end
    if (take) begin
      a_fin <= (items.func == FUNC_FINISH);
      a_cls <= cls;
      for (int l = 0; l < 3; l++) begin
        a_surf_lo[l] <= new_lo[l];
        a_surf_hi[l] <= new_hi[l];
        a_leaf_lo[l] <= leaf_lo[l];
        a_leaf_hi[l] <= leaf_hi[l];
      end
    end
  end

  // per-axis overhang beyond the leaf box, then the largest
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (a_surf_hi[l] > a_leaf_hi[l]) begin
        gap_axis[l] = GAP_W'(a_surf_hi[l]) - GAP_W'(a_leaf_hi[l]);
      end else if (a_surf_lo[l] < a_leaf_lo[l]) begin
        gap_axis[l] = GAP_W'(a_leaf_lo[l]) - GAP_W'(a_surf_lo[l]);
      end else begin
        gap_axis[l] = '0;
      end
    end
    gap_max = gap_axis[0];
    for (int l = 1; l < 3; l++) begin
      if (gap_axis[l] > gap_max) gap_max = gap_axis[l];
    end
  end

  // queue entry, gap saturated at the far limit
  assign push        = a_vld;
  assign push_op.fin = a_fin;
  assign push_op.cls = a_cls;
  assign push_op.gap = (gap_max >= GAP_W'(FAR_LIMIT)) ? FAR_LIMIT : gap_max[DIST_W-1:0];

  a_credit: assert property (@(posedge clk) disable iff (rst)
    (q_count + QCNT_W'(a_vld)) <= QCNT_W'(QUEUE_DEPTH))
    else $error("front overran queue space");

endmodule

// ----- hw/rtl/aslt_back.sv -----
// aslt_back: keeps the nearest distance per class and emits the levels on
// finish through an output register. Depends on aslt_pkg.
module aslt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_vld,
  input  aslt_pkg::aslt_op_t q_op,
  output logic               pop,
  aslt_out_if.source         levels
);
  import aslt_pkg::*;

  logic [DIST_W-1:0]  class_dist [NUM_CLASSES];
  logic               out_vld;
  logic [LEVEL_W-1:0] water_q, sky_q, slime_q, lava_q;

  // volume from distance: full when near, 255*(1024-d)/1024, zero at far
  function automatic logic [LEVEL_W-1:0] volume(input logic [DIST_W-1:0] d);
    logic [DIST_W-1:0]     r;
    logic [DIST_W+LEVEL_W-1:0] prod;
    r    = FAR_LIMIT - d;
    prod = {r, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, r};
    if (d < NEAR_LIMIT) begin
      volume = FULL_VOLUME;
    end else if (d < FAR_LIMIT) begin
      volume = prod[DIST_W+LEVEL_W-2 -: LEVEL_W];
    end else begin
      volume = '0;
    end
  endfunction

  // a finish waits for the output register to be free
  assign pop = q_vld && (!q_op.fin || !out_vld || levels.ready);

  // distances and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) class_dist[c] <= FAR_LIMIT;
      out_vld <= 1'b0;
    end else begin
      if (levels.ready) out_vld <= 1'b0;
      if (pop) begin
        if (q_op.fin) begin
          for (int c = 0; c < NUM_CLASSES; c++) class_dist[c] <= FAR_LIMIT;
          out_vld <= 1'b1;
        end else if (q_op.gap < class_dist[q_op.cls]) begin
          class_dist[q_op.cls] <= q_op.gap;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && q_op.fin) begin
      water_q <= volume(class_dist[CLASS_WATER]);
      sky_q   <= volume(class_dist[CLASS_SKY]);
      slime_q <= volume(class_dist[CLASS_SLIME]);
      lava_q  <= volume(class_dist[CLASS_LAVA]);
    end
  end

  assign levels.valid       = out_vld;
  assign levels.water_level = water_q;
  assign levels.sky_level   = sky_q;
  assign levels.slime_level = slime_q;
  assign levels.lava_level  = lava_q;

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    !(class_dist[CLASS_WATER] > FAR_LIMIT || class_dist[CLASS_SKY] > FAR_LIMIT ||
      class_dist[CLASS_SLIME] > FAR_LIMIT || class_dist[CLASS_LAVA] > FAR_LIMIT))
    else $error("class distance above far limit");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && q_op.fin) |=> (class_dist[CLASS_WATER] == FAR_LIMIT &&
                          class_dist[CLASS_SKY] == FAR_LIMIT &&
                          class_dist[CLASS_SLIME] == FAR_LIMIT &&
                          class_dist[CLASS_LAVA] == FAR_LIMIT))
    else $error("distances not cleared after finish");

endmodule

// ----- hw/rtl/ambient_sound_level_tracker.sv -----
// ambient_sound_level_tracker: top level, front classifier, queue, back.
// A finish item passes the gap stage register and the queue before the output register shows its levels.
// Throughput: one item per cycle; the front stalls only when four operations wait
// in the queue and the gap stage together, i.e. when the levels output is held.
// Reset (synchronous, active high): masks to defaults, leaf box to zero,
// no surface open, every class distance at 1024, queue and output empty.
module ambient_sound_level_tracker #(
  parameter int COORD_WIDTH = aslt_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [aslt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aslt_pkg::CFG_DATA_W-1:0] cfg_data,
  aslt_in_if.sink                         items,
  aslt_out_if.source                      levels
);
  import aslt_pkg::*;

  logic              push;
  aslt_op_t          push_op;
  logic              pop;
  aslt_op_t          pop_op;
  logic              q_vld;
  logic [QCNT_W-1:0] q_count;

  // accept, box tracking and gap measurement
  aslt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .q_count   (q_count),
    .push      (push),
    .push_op   (push_op)
  );

  // decoupling queue
  aslt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .pop       (pop),
    .pop_op    (pop_op),
    .not_empty (q_vld),
    .count     (q_count)
  );

  // distance tracking and level output
  aslt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_vld  (q_vld),
    .q_op   (pop_op),
    .pop    (pop),
    .levels (levels)
  );

endmodule

// ----- verif/ambient_sound_level_tracker_test.sv -----
`timescale 1ns / 100ps
// ambient_sound_level_tracker_test: self-checking bench for the ambient sound level tracker.
// Depends on aslt_pkg, aslt_in_if, aslt_out_if and the ambient_sound_level_tracker rtl.
module ambient_sound_level_tracker_test;
  import aslt_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;

  typedef struct {
    logic [FUNC_W-1:0]    func;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [MASK_W-1:0]    contents;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] water;
    logic [LEVEL_W-1:0] sky;
    logic [LEVEL_W-1:0] slime;
    logic [LEVEL_W-1:0] lava;
  } levels_t;

  // tracks leaf box, surface box and class distances, holds the levels due
  class level_board;
    logic [MASK_W-1:0] mask [5];
    int      leaf_lo [3];
    int      leaf_hi [3];
    int      surf_lo [3];
    int      surf_hi [3];
    bit      surf_open;
    int      near_dist [4];
    levels_t levels_due [$];
    int      errors;
    int      n_checked;

    function new();
      mask[CFG_SKY]   = SKY_MASK_RST;
      mask[CFG_SOLID] = SOLID_MASK_RST;
      mask[CFG_WATER] = WATER_MASK_RST;
      mask[CFG_SLIME] = SLIME_MASK_RST;
      mask[CFG_LAVA]  = LAVA_MASK_RST;
      for (int l = 0; l < 3; l++) begin
        leaf_lo[l] = 0;
        leaf_hi[l] = 0;
        surf_lo[l] = 0;
        surf_hi[l] = 0;
      end
      surf_open = 0;
      for (int j = 0; j < NUM_CLASSES; j++) near_dist[j] = int'(FAR_LIMIT);
      errors = 0;
      n_checked = 0;
    endfunction

    function logic [LEVEL_W-1:0] level_of(int d);
      if (d < int'(NEAR_LIMIT)) return FULL_VOLUME;
      if (d < int'(FAR_LIMIT))
        return LEVEL_W'((int'(FULL_VOLUME) * (int'(FAR_LIMIT) - d)) / int'(FAR_LIMIT));
      return '0;
    endfunction

    // classify a closed surface and lower its class distance
    function void close_surface(logic [MASK_W-1:0] flags);
      int cls;
      int maxd;
      int d;
      maxd = 0;
      if ((flags & mask[CFG_SKY]) != 0) cls = CLASS_SKY;
      else if ((flags & mask[CFG_SOLID]) != 0) return;
      else if ((flags & mask[CFG_WATER]) != 0) cls = CLASS_WATER;
      else if ((flags & mask[CFG_SLIME]) != 0) cls = CLASS_SLIME;
      else if ((flags & mask[CFG_LAVA]) != 0) cls = CLASS_LAVA;
      else return;
      for (int l = 0; l < 3; l++) begin
        if (surf_hi[l] > leaf_hi[l]) d = surf_hi[l] - leaf_hi[l];
        else if (surf_lo[l] < leaf_lo[l]) d = leaf_lo[l] - surf_lo[l];
        else d = 0;
        if (d > maxd) maxd = d;
      end
      if (maxd < near_dist[cls]) near_dist[cls] = maxd;
    endfunction

    // update on an accepted input item
    function void absorb_item(item_t it);
      int p [3];
      levels_t lv;
      p[0] = it.x;
      p[1] = it.y;
      p[2] = it.z;
      case (it.func)
        FUNC_LEAF_LO: for (int l = 0; l < 3; l++) leaf_lo[l] = p[l];
        FUNC_LEAF_HI: for (int l = 0; l < 3; l++) leaf_hi[l] = p[l];
        FUNC_VERTEX: begin
          for (int l = 0; l < 3; l++) begin
            if (!surf_open) begin
              surf_lo[l] = p[l];
              surf_hi[l] = p[l];
            end else begin
              if (p[l] < surf_lo[l]) surf_lo[l] = p[l];
              if (p[l] > surf_hi[l]) surf_hi[l] = p[l];
            end
          end
          if (it.last) begin
            close_surface(it.contents);
            surf_open = 0;
          end else begin
            surf_open = 1;
          end
        end
        FUNC_FINISH: begin
          lv.water = level_of(near_dist[CLASS_WATER]);
          lv.sky   = level_of(near_dist[CLASS_SKY]);
          lv.slime = level_of(near_dist[CLASS_SLIME]);
          lv.lava  = level_of(near_dist[CLASS_LAVA]);
          levels_due.push_back(lv);
          for (int j = 0; j < NUM_CLASSES; j++) near_dist[j] = int'(FAR_LIMIT);
          surf_open = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [LEVEL_W-1:0] want, logic [LEVEL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare an accepted levels item with the oldest one due
    function void compare_levels(levels_t got);
      levels_t want;
      if (levels_due.size() == 0) begin
        $display("%0t: levels item with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      n_checked++;
      check_field("water_level", want.water, got.water);
      check_field("sky_level", want.sky, got.sky);
      check_field("slime_level", want.slime, got.slime);
      check_field("lava_level", want.lava, got.lava);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aslt_in_if #(.COORD_WIDTH(CW)) items_if ();
  aslt_out_if levels_if ();

  ambient_sound_level_tracker #(.COORD_WIDTH(CW)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .levels    (levels_if)
  );

  level_board sb = new();
  int burst_left = 0;
  int items_sent = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  // watch both channels
  always @(posedge clk) begin
    item_t it;
    levels_t got;
    if (!rst) begin
      if (items_if.valid && items_if.ready) begin
        it.func     = items_if.func;
        it.x        = items_if.x_coord;
        it.y        = items_if.y_coord;
        it.z        = items_if.z_coord;
        it.contents = items_if.contents;
        it.last     = items_if.last_vertex;
        sb.absorb_item(it);
      end
      if (levels_if.valid && levels_if.ready) begin
        got.water = levels_if.water_level;
        got.sky   = levels_if.sky_level;
        got.slime = levels_if.slime_level;
        got.lava  = levels_if.lava_level;
        sb.compare_levels(got);
      end
    end
  end

  // receiver: segments of steady, random and sparse ready, one long hold-off
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    bit held;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    held = 0;
    levels_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        levels_if.ready <= 1'b0;
      end else if (!held && sb.n_checked >= 40) begin
        held = 1;
        hold_left = 300;
        levels_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (mode)
          0: levels_if.ready <= 1'b1;
          1: levels_if.ready <= 1'($urandom_range(0, 1));
          default: levels_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic item_t item_of(logic [FUNC_W-1:0] func, int x, int y, int z,
                                    logic [MASK_W-1:0] contents, logic last);
    item_t it;
    it.func     = func;
    it.x        = CW'(x);
    it.y        = CW'(y);
    it.z        = CW'(z);
    it.contents = contents;
    it.last     = last;
    return it;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(int v);
    if (v > 65535) return CW'(65535);
    if (v < -65536) return CW'(-65536);
    return CW'(v);
  endfunction

  // vertex coordinate around a leaf axis, now and then anywhere
  function automatic logic signed [CW-1:0] near_coord(int c, int h);
    int s;
    if ($urandom_range(0, 9) == 0) return CW'($urandom);
    s = h + 1400;
    return clamp_coord(c + int'($urandom_range(0, 2 * s)) - s);
  endfunction

  function automatic logic [MASK_W-1:0] pick_contents();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom;
      6: return sb.mask[$urandom_range(0, 4)] | sb.mask[$urandom_range(0, 4)];
      7: return $urandom & ~(sb.mask[CFG_SKY] | sb.mask[CFG_SOLID]);
      default: return sb.mask[$urandom_range(0, 4)];
    endcase
  endfunction

  // offer one item in bursts with random gaps, wait until taken
  task automatic push_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    items_if.valid       <= 1'b1;
    items_if.func        <= it.func;
    items_if.x_coord     <= it.x;
    items_if.y_coord     <= it.y;
    items_if.z_coord     <= it.z;
    items_if.contents    <= it.contents;
    items_if.last_vertex <= it.last;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic stop_items();
    items_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // all levels in, then let closed surfaces drain out of the queue
  task automatic wait_idle();
    while (sb.levels_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_masks(logic [MASK_W-1:0] sky, logic [MASK_W-1:0] solid,
                             logic [MASK_W-1:0] water, logic [MASK_W-1:0] slime,
                             logic [MASK_W-1:0] lava);
    logic [MASK_W-1:0] vals [5];
    vals[CFG_SKY]   = sky;
    vals[CFG_SOLID] = solid;
    vals[CFG_WATER] = water;
    vals[CFG_SLIME] = slime;
    vals[CFG_LAVA]  = lava;
    for (int i = CFG_SKY; i <= CFG_LAVA; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      sb.mask[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // corner cases under the reset masks
  task automatic run_directed();
    // nothing seen yet
    push_item(item_of(FUNC_FINISH, 0, 0, 0, '0, 1'b0));
    // leaf a: every class once, sky over water, solid ignored, far surface saturates
    push_item(item_of(FUNC_LEAF_LO, 0, 0, 0, '0, 1'b0));
    push_item(item_of(FUNC_LEAF_HI, 100, 100, 100, '0, 1'b0));
    push_item(item_of(FUNC_VERTEX, 300, 50, 50, 32'd32, 1'b1));
    push_item(item_of(FUNC_VERTEX, 50, 50, 50, '0, 1'b0));
    push_item(item_of(FUNC_VERTEX, -1000, 20, 20, 32'd36, 1'b1));
    push_item(item_of(FUNC_VERTEX, 0, 0, 0, 32'd33, 1'b1));
    push_item(item_of(FUNC_VERTEX, -65536, 65535, 0, 32'd16, 1'b1));
    push_item(item_of(FUNC_VERTEX, 150, 50, 50, 32'd8, 1'b1));
    push_item(item_of(FUNC_VERTEX, 10, 10, 10, 32'h40, 1'b1));
    push_item(item_of(FUNC_FINISH, 0, 0, 0, '0, 1'b0));
    // leaf b: swapped corners, open surface dropped at finish, junk fields ignored
    push_item(item_of(FUNC_LEAF_LO, 100, 100, 100, '1, 1'b1));
    push_item(item_of(FUNC_LEAF_HI, 0, 0, 0, '1, 1'b1));
    push_item(item_of(FUNC_VERTEX, 50, 50, 50, 32'd32, 1'b1));
    push_item(item_of(FUNC_VERTEX, 10, 10, 10, 32'd8, 1'b0));
    push_item(item_of(FUNC_FINISH, 65535, -65536, 65535, '1, 1'b1));
    push_item(item_of(FUNC_VERTEX, 120, 50, 50, 32'd8, 1'b1));
    push_item(item_of(FUNC_FINISH, -65536, 65535, -65536, '0, 1'b0));
    // leaf c: gaps at the volume breakpoints
    push_item(item_of(FUNC_LEAF_LO, 0, 0, 0, '0, 1'b0));
    push_item(item_of(FUNC_LEAF_HI, 0, 0, 0, '0, 1'b0));
    push_item(item_of(FUNC_VERTEX, 128, 0, 0, 32'd32, 1'b1));
    push_item(item_of(FUNC_VERTEX, 0, -127, 0, 32'd4, 1'b1));
    push_item(item_of(FUNC_VERTEX, 0, 0, 1023, 32'd16, 1'b1));
    push_item(item_of(FUNC_VERTEX, 1024, 0, 0, 32'd8, 1'b1));
    push_item(item_of(FUNC_FINISH, 0, 0, 0, '0, 1'b0));
    stop_items();
  endtask

  // one leaf: mostly well formed, sometimes noise or broken surfaces
  task automatic run_leaf();
    int c [3];
    int h [3];
    int lo [3];
    int hi [3];
    int nv;
    bit swap;
    item_t it;
    if ($urandom_range(0, 99) < 85) begin
      swap = ($urandom_range(0, 19) == 0);
      for (int l = 0; l < 3; l++) begin
        if ($urandom_range(0, 9) == 0) c[l] = $urandom_range(0, 1) ? 65000 : -65000;
        else c[l] = int'($urandom_range(0, 128000)) - 64000;
        h[l] = $urandom_range(0, 600);
        lo[l] = swap ? c[l] + h[l] : c[l] - h[l];
        hi[l] = swap ? c[l] - h[l] : c[l] + h[l];
      end
      it = item_of(FUNC_LEAF_LO, 0, 0, 0, $urandom, 1'($urandom_range(0, 1)));
      it.x = clamp_coord(lo[0]);
      it.y = clamp_coord(lo[1]);
      it.z = clamp_coord(lo[2]);
      push_item(it);
      it.func = FUNC_LEAF_HI;
      it.x = clamp_coord(hi[0]);
      it.y = clamp_coord(hi[1]);
      it.z = clamp_coord(hi[2]);
      push_item(it);
      repeat ($urandom_range(0, 6)) begin
        nv = $urandom_range(1, 4);
        for (int v = 0; v < nv; v++) begin
          it.func = FUNC_VERTEX;
          it.x = near_coord(c[0], h[0]);
          it.y = near_coord(c[1], h[1]);
          it.z = near_coord(c[2], h[2]);
          it.contents = pick_contents();
          it.last = (v == nv - 1) && ($urandom_range(0, 19) != 0);
          push_item(it);
        end
      end
      push_item(item_of(FUNC_FINISH, int'($urandom), int'($urandom), int'($urandom),
                        $urandom, 1'($urandom_range(0, 1))));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        it.func = FUNC_W'($urandom_range(0, 3));
        it.x = CW'($urandom);
        it.y = CW'($urandom);
        it.z = CW'($urandom);
        it.contents = $urandom;
        it.last = 1'($urandom_range(0, 1));
        push_item(it);
      end
    end
  endtask

  task automatic run_random(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) run_leaf();
    stop_items();
  endtask

  function automatic logic [MASK_W-1:0] sparse_mask();
    return $urandom & $urandom & $urandom;
  endfunction

  // main sequence
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    items_if.valid <= 1'b0;
    items_if.func <= FUNC_LEAF_LO;
    items_if.x_coord <= '0;
    items_if.y_coord <= '0;
    items_if.z_coord <= '0;
    items_if.contents <= '0;
    items_if.last_vertex <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    wait_idle();
    run_random(600);

    // zero masks: nothing classifies
    wait_idle();
    write_masks('0, '0, '0, '0, '0);
    run_random(150);

    // full masks: any flag is sky
    wait_idle();
    write_masks('1, '1, '1, '1, '1);
    run_random(150);

    // one bit per class
    wait_idle();
    write_masks(32'd1 << $urandom_range(0, 31), 32'd1 << $urandom_range(0, 31),
                32'd1 << $urandom_range(0, 31), 32'd1 << $urandom_range(0, 31),
                32'd1 << $urandom_range(0, 31));
    run_random(500);

    // sparse, overlapping masks
    wait_idle();
    write_masks(sparse_mask(), sparse_mask(), sparse_mask(), sparse_mask(), sparse_mask());
    run_random(500);

    while (sb.levels_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.levels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
